### hdl/gsc_pkg.sv
// Shared types and constants for the gauge scale, calibrate and colour block.
// Used by every module under hdl; depends on nothing else.
package gsc_pkg;

	localparam int unsigned LevelW  = 12;
	localparam int unsigned MagW    = 50;
	localparam int unsigned FrontN  = 4;
	localparam int unsigned DivN    = LevelW;
	localparam int unsigned BackN   = 2;
	localparam int unsigned StageN  = FrontN + DivN + BackN;
	localparam logic [LevelW-1:0] LevelMax = 12'hfff;
	localparam logic [15:0] BlendCode = 16'hffff;

	// register indexes
	localparam logic [2:0] RegScaleLow  = 3'd0;
	localparam logic [2:0] RegScaleHigh = 3'd1;
	localparam logic [2:0] RegUnitDiv   = 3'd2;
	localparam logic [2:0] RegCalLow    = 3'd3;
	localparam logic [2:0] RegCalHigh   = 3'd4;
	localparam logic [2:0] RegStartCol  = 3'd5;
	localparam logic [2:0] RegEndCol    = 3'd6;
	localparam logic [2:0] RegColThresh = 3'd7;

	typedef struct packed {
		logic signed [31:0] scale_low;
		logic signed [31:0] scale_high;
		logic [15:0]        unit_divider;
		logic [11:0]        cal_low;
		logic [11:0]        cal_high;
		logic [15:0]        start_color;
		logic [15:0]        end_color;
		logic [15:0]        color_threshold;
	} cfg_t;

	// word travelling through the divider stages
	typedef struct packed {
		logic [MagW-1:0]   rem;
		logic [MagW-1:0]   den;
		logic [LevelW-1:0] quo;
		logic              force0;
		logic              sat;
		logic              err;
	} div_t;

	typedef struct packed {
		logic [23:0]       color;
		logic [LevelW-1:0] pwm;
		logic [LevelW-1:0] level;
		logic              err;
	} res_t;

endpackage

### hdl/gsc_front.sv
// Front end: scale products, numerator, magnitudes and range flags (four stages).
// Depends on gsc_pkg.
module gsc_front (
	input  logic                 clk,
	input  gsc_pkg::cfg_t        cfg,
	input  logic [3:0]           en,
	input  logic signed [31:0]   value,
	output gsc_pkg::div_t        dout
);

	logic signed [31:0] value_s1;
	logic signed [48:0] lowdiv_s1;
	logic signed [49:0] den_s1;
	logic signed [49:0] num_s2;
	logic signed [49:0] den_s2;
	logic [gsc_pkg::MagW-1:0] amag_s3;
	logic [gsc_pkg::MagW-1:0] dmag_s3;
	logic                     negq_s3;
	logic                     err_s3;
	gsc_pkg::div_t            div_s4;

	logic signed [32:0] span;
	logic signed [16:0] divs;
	logic               sat;
	logic               zero_res;

	assign span = $signed({cfg.scale_high[31], cfg.scale_high})
	            - $signed({cfg.scale_low[31], cfg.scale_low});
	assign divs = $signed({1'b0, cfg.unit_divider});

	// stage 1: products of the scale registers with the divider
	always_ff @(posedge clk) begin
		if (en[0]) begin
			value_s1  <= value;
			lowdiv_s1 <= cfg.scale_low * divs;
			den_s1    <= span * divs;
		end
	end

	// stage 2: numerator before the implied 4096 factor
	always_ff @(posedge clk) begin
		if (en[1]) begin
			num_s2 <= $signed({{18{value_s1[31]}}, value_s1})
			        - $signed({lowdiv_s1[48], lowdiv_s1});
			den_s2 <= den_s1;
		end
	end

	// stage 3: magnitudes and sign of the quotient
	always_ff @(posedge clk) begin
		if (en[2]) begin
			amag_s3 <= num_s2[49] ? 50'(-num_s2) : 50'(num_s2);
			dmag_s3 <= den_s2[49] ? 50'(-den_s2) : 50'(den_s2);
			negq_s3 <= num_s2[49] ^ den_s2[49];
			err_s3  <= (den_s2 == '0);
		end
	end

	// stage 4: saturation test, set up the restoring divider
	assign sat      = (amag_s3 >= dmag_s3);
	assign zero_res = err_s3 | negq_s3;

	always_ff @(posedge clk) begin
		if (en[3]) begin
			div_s4.rem    <= (sat | zero_res) ? '0 : amag_s3;
			div_s4.den    <= dmag_s3;
			div_s4.quo    <= '0;
			div_s4.force0 <= zero_res;
			div_s4.sat    <= sat & ~zero_res;
			div_s4.err    <= err_s3;
		end
	end

	assign dout = div_s4;

endmodule

### hdl/gsc_div_step.sv
// One quotient bit of the restoring divider, registered.
// Depends on gsc_pkg.
module gsc_div_step (
	input  logic          clk,
	input  logic          en,
	input  gsc_pkg::div_t din,
	output gsc_pkg::div_t dout
);

	logic [gsc_pkg::MagW-1:0] rem2;
	logic                     take;
	gsc_pkg::div_t            nxt;
	gsc_pkg::div_t            step_s1;

	assign rem2 = {din.rem[gsc_pkg::MagW-2:0], 1'b0};
	assign take = (rem2 >= din.den);

	// next word: shifted remainder, conditional subtract, one more quotient bit
	always_comb begin
		nxt     = din;
		nxt.rem = take ? (rem2 - din.den) : rem2;
		nxt.quo = {din.quo[gsc_pkg::LevelW-2:0], take};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			step_s1 <= nxt;
		end
	end

	assign dout = step_s1;

endmodule

### hdl/gsc_back.sv
// Back end: level clamp, PWM calibration and colour (two stages).
// Depends on gsc_pkg.
module gsc_back (
	input  logic          clk,
	input  gsc_pkg::cfg_t cfg,
	input  logic [1:0]    en,
	input  gsc_pkg::div_t din,
	output gsc_pkg::res_t dout
);

	logic [11:0]        lev;
	logic signed [12:0] cspan;
	logic [11:0]        inv;

	logic [11:0]        lev_s1;
	logic               err_s1;
	logic signed [25:0] prod_s1;
	logic [17:0]        sumr_s1;
	logic [18:0]        sumg_s1;
	logic [17:0]        sumb_s1;
	gsc_pkg::res_t      res_s2;

	logic [11:0] pwm;
	logic [7:0]  cr, cg, cb;
	logic [15:0] pick;

	assign lev = din.force0 ? '0 : (din.sat ? gsc_pkg::LevelMax : din.quo);
	assign inv = gsc_pkg::LevelMax - lev;
	assign cspan = $signed({1'b0, cfg.cal_high}) - $signed({1'b0, cfg.cal_low});

	// stage 1: calibration product and blend sums
	always_ff @(posedge clk) begin
		if (en[0]) begin
			lev_s1  <= lev;
			err_s1  <= din.err;
			prod_s1 <= cspan * $signed({1'b0, lev});
			sumr_s1 <= 18'(cfg.end_color[15:11] * lev) + 18'(cfg.start_color[15:11] * inv);
			sumg_s1 <= 19'(cfg.end_color[10:5] * lev) + 19'(cfg.start_color[10:5] * inv);
			sumb_s1 <= 18'(cfg.end_color[4:0] * lev) + 18'(cfg.start_color[4:0] * inv);
		end
	end

	// stage 2: PWM count, saturating blend or threshold pick
	assign pwm = (cfg.cal_high == cfg.cal_low) ? lev_s1
	           : (cfg.cal_low + prod_s1[23:12]);
	assign pick = ({4'b0, lev_s1} > cfg.color_threshold) ? cfg.end_color : cfg.start_color;

	always_comb begin
		if (cfg.color_threshold == gsc_pkg::BlendCode) begin
			cr = (sumr_s1[17:9] > 9'd255) ? 8'hff : sumr_s1[16:9];
			cg = (sumg_s1[18:10] > 9'd255) ? 8'hff : sumg_s1[17:10];
			cb = (sumb_s1[17:9] > 9'd255) ? 8'hff : sumb_s1[16:9];
		end else begin
			cr = {pick[15:11], 3'b0};
			cg = {pick[10:5], 2'b0};
			cb = {pick[4:0], 3'b0};
		end
	end

	always_ff @(posedge clk) begin
		if (en[1]) begin
			res_s2.level <= lev_s1;
			res_s2.pwm   <= pwm;
			res_s2.color <= {cb, cg, cr};
			res_s2.err   <= err_s1;
		end
	end

	assign dout = res_s2;

endmodule

### hdl/gauge_scale_calibrate_color.sv
// Top level of the gauge channel: registers, valid chain and stage wiring.
// Depends on gsc_pkg, gsc_front, gsc_div_step and gsc_back.
//
// Usage:
//   s_* carries one telemetry word (signed 32 bit) per accepted beat.
//   m_* returns one result word per sample: level, PWM count, RGB888
//   colour in tdata and the range error flag in tuser.
//   cfg_* writes register cfg_index with cfg_data; always ready. Write only
//   while no sample is in flight.
// From acceptance to m_tvalid a sample passes four front stages
// (products, numerator, magnitudes, saturation test), twelve divider stages
// of one quotient bit each, and two mapping stages.
// Throughput is one sample per cycle while m_tready is high; every stage holds a valid bit.
// A stalled receiver freezes only the stages that are full behind it, so
// bubbles still close up and s_tready stays high until the pipe is full.
// Reset clears all valid bits and loads the register defaults.
module gauge_scale_calibrate_color (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // [31:0] telemetry_value
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,   // [11:0] gauge_level, [23:12] pwm_drive, [47:24] gauge_color
	output logic [0:0]  m_tuser,   // [0] range_error
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	localparam int unsigned N = gsc_pkg::StageN;
	localparam int unsigned F = gsc_pkg::FrontN;
	localparam int unsigned D = gsc_pkg::DivN;

	gsc_pkg::cfg_t cfg_q;
	logic [N-1:0]  valid_q;
	logic [N:0]    en;
	gsc_pkg::div_t div_w [0:D];
	gsc_pkg::res_t res;

	// register file
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.scale_low       <= '0;
			cfg_q.scale_high      <= '0;
			cfg_q.unit_divider    <= 16'd1;
			cfg_q.cal_low         <= '0;
			cfg_q.cal_high        <= 12'hfff;
			cfg_q.start_color     <= '0;
			cfg_q.end_color       <= '0;
			cfg_q.color_threshold <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				gsc_pkg::RegScaleLow:  cfg_q.scale_low       <= cfg_data;
				gsc_pkg::RegScaleHigh: cfg_q.scale_high      <= cfg_data;
				gsc_pkg::RegUnitDiv:   cfg_q.unit_divider    <= cfg_data[15:0];
				gsc_pkg::RegCalLow:    cfg_q.cal_low         <= cfg_data[11:0];
				gsc_pkg::RegCalHigh:   cfg_q.cal_high        <= cfg_data[11:0];
				gsc_pkg::RegStartCol:  cfg_q.start_color     <= cfg_data[15:0];
				gsc_pkg::RegEndCol:    cfg_q.end_color       <= cfg_data[15:0];
				gsc_pkg::RegColThresh: cfg_q.color_threshold <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	// stage enables: a stage moves when empty or when the one after moves
	always_comb begin
		en[N] = m_tready;
		for (int i = N - 1; i >= 0; i--) begin
			en[i] = ~valid_q[i] | en[i+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else begin
			for (int i = 0; i < N; i++) begin
				if (en[i]) begin
					valid_q[i] <= (i == 0) ? s_tvalid : valid_q[(i == 0) ? 0 : i - 1];
				end
			end
		end
	end

	assign s_tready = en[0];

	gsc_front u_front (
		.clk   (clk),
		.cfg   (cfg_q),
		.en    (en[F-1:0]),
		.value (s_tdata),
		.dout  (div_w[0])
	);

	for (genvar k = 0; k < D; k++) begin : g_div
		gsc_div_step u_step (
			.clk  (clk),
			.en   (en[F+k]),
			.din  (div_w[k]),
			.dout (div_w[k+1])
		);
	end

	gsc_back u_back (
		.clk  (clk),
		.cfg  (cfg_q),
		.en   (en[N-1:F+D]),
		.din  (div_w[D]),
		.dout (res)
	);

	assign m_tvalid = valid_q[N-1];
	assign m_tdata  = {res.color, res.pwm, res.level};
	assign m_tuser  = res.err;

endmodule
